>>> design/urssi_pkg.sv
// Shared constants, types and log-table helpers for the receive level estimator.
package urssi_pkg;

    localparam int LOG_FRAC_BITS = 8;
    localparam int FRAC_ENTRIES  = 1 << LOG_FRAC_BITS;
    localparam int FRAC_W        = 16;
    localparam int IN_W          = 16;
    localparam int POS_W         = 4;
    localparam int LOG_W         = POS_W + FRAC_W;
    localparam int L2_W          = 24;
    localparam int PROD_W        = 43;
    localparam int LVL_W         = 18;
    localparam int OVER_W        = 16;
    localparam int K_W           = 18;
    localparam int CORR_W        = OVER_W + K_W;
    localparam int OUT_W         = 17;

    localparam logic signed [L2_W-1:0]   L2_BIAS      = L2_W'(17 * 65536);
    localparam logic signed [18:0]       TEN_LOG10_2  = 19'sd197283;
    localparam logic signed [PROD_W-1:0] ROUND_HALF   = PROD_W'(1 << 23);
    localparam logic signed [LVL_W-1:0]  A64_Q8       = 18'sd31165;
    localparam logic signed [LVL_W-1:0]  A16_Q8       = 18'sd29125;
    localparam logic signed [LVL_W-1:0]  KNEE_Q8      = -18'sd22528;
    localparam logic [K_W-1:0]           K64_Q16      = 18'd76461;
    localparam logic [K_W-1:0]           K16_Q16      = 18'd152922;
    localparam logic [CORR_W:0]          CORR_HALF    = (CORR_W+1)'(32768);
    localparam logic signed [19:0]       LVL_FLOOR_W  = -20'sd38400;
    localparam logic signed [19:0]       LVL_MAX_W    = 20'sd40960;
    localparam logic signed [OUT_W-1:0]  LVL_FLOOR_Q8 = -17'sd38400;

    localparam logic PRF_64M = 1'b0;
    localparam logic PRF_16M = 1'b1;

    typedef logic [FRAC_W-1:0] t_frac_rom [FRAC_ENTRIES];

    typedef struct packed {
        logic                   valid;
        logic                   flag;
        logic                   prf;
        logic signed [L2_W-1:0] l2;
    } t_log_out;

    function automatic t_frac_rom build_frac_rom();
        t_frac_rom         rom;
        logic [63:0]       y;
        logic [FRAC_W-1:0] acc;
        for (int i = 0; i < FRAC_ENTRIES; i++) begin
            y   = (64'd1 << 30) + (64'(i) << (30 - LOG_FRAC_BITS));
            acc = '0;
            for (int b = 0; b < FRAC_W; b++) begin
                y   = (y * y) >> 30;
                acc = {acc[FRAC_W-2:0], 1'b0};
                if (y >= (64'd1 << 31)) begin
                    acc[0] = 1'b1;
                    y      = y >> 1;
                end
            end
            rom[i] = acc;
        end
        return rom;
    endfunction

    localparam t_frac_rom FRAC_ROM = build_frac_rom();

    function automatic logic [POS_W-1:0] lead_pos(input logic [IN_W-1:0] x);
        logic [POS_W-1:0] pos;
        pos = '0;
        for (int b = 0; b < IN_W; b++) begin
            if (x[b]) begin
                pos = POS_W'(b);
            end
        end
        return pos;
    endfunction

    function automatic logic [LOG_FRAC_BITS-1:0] frac_index(input logic [IN_W-1:0] x,
                                                           input logic [POS_W-1:0] pos);
        logic [IN_W+LOG_FRAC_BITS-1:0] wide;
        wide = {x, {LOG_FRAC_BITS{1'b0}}} >> pos;
        return wide[LOG_FRAC_BITS-1:0];
    endfunction

endpackage

>>> design/urssi_log2diff.sv
// Leading-one search, fraction table lookup and log2 difference pipeline stages.
module urssi_log2diff import urssi_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_prf,
    input  logic [15:0]     i_cir_power,
    input  logic [11:0]     i_preamble_count,
    output t_log_out        o_log
);

    logic [IN_W-1:0]          n_c;
    logic [IN_W-1:0]          n_n;
    logic [POS_W-1:0]         n_pos_c;
    logic [POS_W-1:0]         n_pos_n;

    logic                     r_a_valid;
    logic                     r_a_flag;
    logic                     r_a_prf;
    logic [POS_W-1:0]         r_pos_c;
    logic [POS_W-1:0]         r_pos_n;
    logic [LOG_FRAC_BITS-1:0] r_idx_c;
    logic [LOG_FRAC_BITS-1:0] r_idx_n;

    logic [LOG_W-1:0]         n_log_c;
    logic [LOG_W-1:0]         n_log_n;
    t_log_out                 r_b;

    assign n_c     = i_cir_power;
    assign n_n     = {4'd0, i_preamble_count};
    assign n_pos_c = lead_pos(n_c);
    assign n_pos_n = lead_pos(n_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
        r_a_flag <= (i_cir_power == '0) || (i_preamble_count == '0);
        r_a_prf  <= i_prf;
        r_pos_c  <= n_pos_c;
        r_pos_n  <= n_pos_n;
        r_idx_c  <= frac_index(n_c, n_pos_c);
        r_idx_n  <= frac_index(n_n, n_pos_n);
    end

    assign n_log_c = {r_pos_c, FRAC_ROM[r_idx_c]};
    assign n_log_n = {r_pos_n, FRAC_ROM[r_idx_n]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.valid <= 1'b0;
        end else begin
            r_b.valid <= r_a_valid;
        end
        r_b.flag <= r_a_flag;
        r_b.prf  <= r_a_prf;
        r_b.l2   <= $signed({4'd0, n_log_c}) - $signed({3'd0, n_log_n, 1'b0}) + L2_BIAS;
    end

    assign o_log = r_b;

endmodule

>>> design/urssi_dbm.sv
// Scaling to dB, mode offset, knee correction and saturation pipeline stages.
module urssi_dbm import urssi_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_log_out                i_log,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_level_q8,
    output logic                    o_floor_flag
);

    logic                     r_c_valid;
    logic                     r_c_flag;
    logic                     r_c_prf;
    logic signed [PROD_W-1:0] r_prod;

    logic signed [PROD_W-1:0] n_rounded;
    logic signed [LVL_W-1:0]  n_level;
    logic signed [LVL_W-1:0]  n_over;
    logic                     n_above;

    logic                     r_d_valid;
    logic                     r_d_flag;
    logic                     r_d_prf;
    logic                     r_d_above;
    logic signed [LVL_W-1:0]  r_d_level;
    logic [OVER_W-1:0]        r_d_over;

    logic                     r_e_valid;
    logic                     r_e_flag;
    logic                     r_e_above;
    logic signed [LVL_W-1:0]  r_e_level;
    logic [CORR_W-1:0]        r_corr;

    logic [CORR_W:0]          n_corr_rnd;
    logic signed [19:0]       n_sum;
    logic signed [19:0]       n_sat;

    logic                     r_valid;
    logic                     r_flag;
    logic signed [OUT_W-1:0]  r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= i_log.valid;
        end
        r_c_flag <= i_log.flag;
        r_c_prf  <= i_log.prf;
        r_prod   <= PROD_W'(i_log.l2) * PROD_W'(TEN_LOG10_2);
    end

    assign n_rounded = (r_prod + ROUND_HALF) >>> 24;
    assign n_level   = n_rounded[LVL_W-1:0] - ((r_c_prf == PRF_16M) ? A16_Q8 : A64_Q8);
    assign n_above   = n_level > KNEE_Q8;
    assign n_over    = n_level - KNEE_Q8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else begin
            r_d_valid <= r_c_valid;
        end
        r_d_flag  <= r_c_flag;
        r_d_prf   <= r_c_prf;
        r_d_above <= n_above;
        r_d_level <= n_level;
        r_d_over  <= n_above ? n_over[OVER_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else begin
            r_e_valid <= r_d_valid;
        end
        r_e_flag  <= r_d_flag;
        r_e_above <= r_d_above;
        r_e_level <= r_d_level;
        r_corr    <= CORR_W'(r_d_over) * CORR_W'((r_d_prf == PRF_16M) ? K16_Q16 : K64_Q16);
    end

    assign n_corr_rnd = {1'b0, r_corr} + CORR_HALF;
    assign n_sum      = 20'(r_e_level) +
                        (r_e_above ? $signed({1'b0, n_corr_rnd[CORR_W:16]}) : 20'sd0);

    always_comb begin
        priority if (r_e_flag || (n_sum < LVL_FLOOR_W)) begin
            n_sat = LVL_FLOOR_W;
        end else if (n_sum > LVL_MAX_W) begin
            n_sat = LVL_MAX_W;
        end else begin
            n_sat = n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_e_valid;
        end
        r_flag  <= r_e_flag;
        r_level <= n_sat[OUT_W-1:0];
    end

    assign o_valid      = r_valid;
    assign o_level_q8   = r_level;
    assign o_floor_flag = r_flag;

endmodule

>>> design/uwb_rssi_estimator.sv
// Top level of the receive level estimator: configuration register and pipeline.
// A result appears on o_valid after the start transfer is accepted, for one cycle.
// Throughput: one transfer per cycle; busy is always low as every stage advances each cycle.
// The depth is set by the leading-one, log table, dB multiplier, knee, correction multiplier and saturation stages.
// Synchronous active-low reset empties the pipeline and sets the rate mode to 64 MHz.
module uwb_rssi_estimator import urssi_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_wdata,
    input  logic                    start,
    output logic                    busy,
    input  logic [15:0]             i_cir_power,
    input  logic [11:0]             i_preamble_count,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_level_q8,
    output logic                    o_floor_flag
);

    logic     r_prf_mode;
    t_log_out log_bus;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prf_mode <= PRF_64M;
        end else if (i_cfg_we) begin
            r_prf_mode <= i_cfg_wdata;
        end
    end

    assign busy = 1'b0;

    urssi_log2diff u_log2diff (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (start && !busy),
        .i_prf            (r_prf_mode),
        .i_cir_power      (i_cir_power),
        .i_preamble_count (i_preamble_count),
        .o_log            (log_bus)
    );

    urssi_dbm u_dbm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_log        (log_bus),
        .o_valid      (o_valid),
        .o_level_q8   (o_level_q8),
        .o_floor_flag (o_floor_flag)
    );

endmodule

>>> design/urssi_checker.sv
// Port-level assertions for the receive level estimator, bound to the top level.
module urssi_checker import urssi_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    start,
    input logic                    busy,
    input logic [15:0]             i_cir_power,
    input logic [11:0]             i_preamble_count,
    input logic                    o_valid,
    input logic signed [OUT_W-1:0] o_level_q8,
    input logic                    o_floor_flag
);

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##6 o_valid)
        else $error("accepted transfer gave no result after six cycles");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 6))
        else $error("result without a matching transfer");

    a_zero_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cir_power == 16'd0 || i_preamble_count == 12'd0))
        |-> ##6 (o_floor_flag && o_level_q8 == LVL_FLOOR_Q8))
        else $error("zero input did not give the floor level");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_level_q8 >= LVL_FLOOR_Q8 && o_level_q8 <= 17'sd40960))
        else $error("level outside its range");

endmodule

bind uwb_rssi_estimator urssi_checker u_urssi_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .i_cir_power      (i_cir_power),
    .i_preamble_count (i_preamble_count),
    .o_valid          (o_valid),
    .o_level_q8       (o_level_q8),
    .o_floor_flag     (o_floor_flag)
);

>>> tb/uwb_rssi_estimator_test.sv
// Self-checking testbench for the receive level estimator, with its own fixed-point predictor.
module uwb_rssi_estimator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int    FRAC_BITS   = urssi_pkg::LOG_FRAC_BITS;
    localparam int    LEVEL_W     = urssi_pkg::OUT_W;
    localparam longint FLOOR_Q8    = -38400;
    localparam longint CEILING_Q8  = 40960;
    localparam longint KNEE_LVL_Q8 = -22528;
    localparam longint DB_PER_OCT  = 197283;
    localparam longint OFFSET_64M  = 31165;
    localparam longint OFFSET_16M  = 29125;
    localparam longint SLOPE_64M   = 76461;
    localparam longint SLOPE_16M   = 152922;
    localparam int    SETTLE_CYC  = 12;

    typedef struct {
        logic signed [LEVEL_W-1:0] level;
        logic                      floor_hit;
    } t_level_result;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic                      cfg_wdata = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [15:0]               cir_power = '0;
    logic [11:0]               preamble_count = '0;
    logic                      res_valid;
    logic signed [LEVEL_W-1:0] res_level;
    logic                      res_floor;

    t_level_result pending_levels[$];
    logic          prf_mode_q = urssi_pkg::PRF_64M;
    int            error_count = 0;

    uwb_rssi_estimator i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .start            (start),
        .busy             (busy),
        .i_cir_power      (cir_power),
        .i_preamble_count (preamble_count),
        .o_valid          (res_valid),
        .o_level_q8       (res_level),
        .o_floor_flag     (res_floor)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic longint mantissa_log(input int unsigned idx);
        logic [63:0] y;
        longint      acc;
        y   = (64'd1 << 30) + (64'(idx) << (30 - FRAC_BITS));
        acc = 0;
        repeat (16) begin
            y   = (y * y) >> 30;
            acc = acc * 2;
            if (y >= (64'd1 << 31)) begin
                acc = acc + 1;
                y   = y >> 1;
            end
        end
        return acc;
    endfunction

    function automatic longint log2_fixed(input logic [15:0] x);
        int          msb;
        logic [31:0] shifted;
        msb = 0;
        for (int b = 0; b < 16; b++) begin
            if (x[b]) begin
                msb = b;
            end
        end
        shifted = ({16'd0, x} << FRAC_BITS) >> msb;
        return longint'(msb) * 65536
               + mantissa_log(int'(shifted & ((32'd1 << FRAC_BITS) - 1)));
    endfunction

    function automatic t_level_result estimate_level(input logic [15:0] c, input logic [11:0] n,
                                                     input logic mode);
        t_level_result r;
        longint        l2;
        longint        lvl;
        longint        slope;
        if (c == 0 || n == 0) begin
            r.level     = LEVEL_W'(FLOOR_Q8);
            r.floor_hit = 1'b1;
            return r;
        end
        l2    = log2_fixed(c) - 2 * log2_fixed({4'd0, n}) + 17 * 65536;
        lvl   = (l2 * DB_PER_OCT + (longint'(1) << 23)) >>> 24;
        lvl   = lvl - ((mode == urssi_pkg::PRF_16M) ? OFFSET_16M : OFFSET_64M);
        slope = (mode == urssi_pkg::PRF_16M) ? SLOPE_16M : SLOPE_64M;
        if (lvl > KNEE_LVL_Q8) begin
            lvl = lvl + (((lvl - KNEE_LVL_Q8) * slope + 32768) >>> 16);
        end
        if (lvl < FLOOR_Q8) begin
            lvl = FLOOR_Q8;
        end
        if (lvl > CEILING_Q8) begin
            lvl = CEILING_Q8;
        end
        r.level     = LEVEL_W'(lvl);
        r.floor_hit = 1'b0;
        return r;
    endfunction

    always @(posedge clk) begin
        t_level_result want;
        if (!rst_n) begin
            prf_mode_q <= urssi_pkg::PRF_64M;
        end else begin
            if (res_valid) begin
                if (pending_levels.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result level %0d flag %0b",
                             $time, res_level, res_floor);
                end else begin
                    want = pending_levels.pop_front();
                    if (res_level !== want.level) begin
                        error_count++;
                        $display("%0t: level expected %0d actual %0d",
                                 $time, want.level, res_level);
                    end
                    if (res_floor !== want.floor_hit) begin
                        error_count++;
                        $display("%0t: floor flag expected %0b actual %0b",
                                 $time, want.floor_hit, res_floor);
                    end
                end
            end
            if (start && !busy) begin
                pending_levels.push_back(estimate_level(cir_power, preamble_count, prf_mode_q));
            end
            if (cfg_we) begin
                prf_mode_q <= cfg_wdata;
            end
        end
    end

    task automatic send_frame(input logic [15:0] c, input logic [11:0] n);
        @(negedge clk);
        start          <= 1'b1;
        cir_power      <= c;
        preamble_count <= n;
        do @(posedge clk); while (busy);
    endtask

    task automatic idle_cycle();
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic wait_idle();
        idle_cycle();
        while (pending_levels.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYC) idle_cycle();
    endtask

    task automatic set_prf_mode(input logic mode);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [15:0] random_power();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            return '0;
        end else if (pick < 50) begin
            return 16'($urandom_range(0, 65535));
        end
        return 16'($urandom) & 16'((32'd1 << $urandom_range(1, 16)) - 1);
    endfunction

    function automatic logic [11:0] random_count();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            return '0;
        end else if (pick < 50) begin
            return 12'($urandom_range(0, 4095));
        end
        return 12'($urandom) & 12'((32'd1 << $urandom_range(1, 12)) - 1);
    endfunction

    task automatic test_floor_cases();
        send_frame(16'd0, 12'd0);
        send_frame(16'd0, 12'd4095);
        send_frame(16'd65535, 12'd0);
        send_frame(16'd0, 12'd1);
        send_frame(16'd1, 12'd0);
    endtask

    task automatic test_extreme_inputs(input logic mode);
        set_prf_mode(mode);
        send_frame(16'd1, 12'd1);
        send_frame(16'd65535, 12'd1);
        send_frame(16'd1, 12'd4095);
        send_frame(16'd65535, 12'd4095);
        send_frame(16'hAAAA, 12'h555);
        send_frame(16'h5555, 12'hAAA);
        send_frame(16'd255, 12'd7);
        send_frame(16'd40000, 12'd64);
    endtask

    task automatic test_random_traffic(input logic mode, input int idle_pct, input int frames);
        set_prf_mode(mode);
        for (int i = 0; i < frames; i++) begin
            while ($urandom_range(0, 99) < idle_pct) begin
                idle_cycle();
            end
            send_frame(random_power(), random_count());
        end
    endtask

    initial begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        test_floor_cases();
        test_extreme_inputs(urssi_pkg::PRF_64M);
        test_extreme_inputs(urssi_pkg::PRF_16M);
        test_random_traffic(urssi_pkg::PRF_64M, 0, 250);
        test_random_traffic(urssi_pkg::PRF_16M, 0, 250);
        test_random_traffic(urssi_pkg::PRF_64M, 45, 250);
        test_random_traffic(urssi_pkg::PRF_16M, 45, 250);
        test_random_traffic(urssi_pkg::PRF_64M, 37, 250);
        test_random_traffic(urssi_pkg::PRF_16M, 37, 250);
        test_random_traffic(urssi_pkg::PRF_64M, 0, 250);
        test_random_traffic(urssi_pkg::PRF_16M, 45, 250);
        wait_idle();
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> sim.f
design/urssi_pkg.sv
design/urssi_log2diff.sv
design/urssi_dbm.sv
design/uwb_rssi_estimator.sv
design/urssi_checker.sv
tb/uwb_rssi_estimator_test.sv
